### hdl/cpct_pkg.sv
// ---------------------------------------------------------------------------
// cpct_pkg
// Shared types and constants for the collider pair contact tracker.
// ---------------------------------------------------------------------------
package cpct_pkg;

   localparam int ID_BITS_DEFAULT = 4;
   localparam int POS_W   = 24;
   localparam int SIZE_W  = 16;
   localparam int SCALE_W = 8;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd100;

   // Scaled size: 16 x 8 bits.
   localparam int SS_W = SIZE_W + SCALE_W;
   // Doubled coordinates, and sums of doubled coordinates with sizes.
   localparam int D_W  = POS_W + SS_W;
   // Every doubled delta magnitude, limit and radius stays below 2^26.
   localparam int MAG_W = POS_W + 2;
   // Squared distances.
   localparam int SQ_W = 2 * MAG_W + 1;

   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_ENTER = 2'd1;
   localparam logic [1:0] EV_STAY  = 2'd2;
   localparam logic [1:0] EV_EXIT  = 2'd3;

   localparam logic KIND_RECT   = 1'b0;
   localparam logic KIND_CIRCLE = 1'b1;

   typedef struct packed {
      logic [1:0]             mode;     // {first_kind, second_kind}
      logic signed [D_W-1:0]  dx;       // centre or clamp delta, doubled
      logic signed [D_W-1:0]  dy;
      logic [D_W-1:0]         lim_x;    // rect-rect limits or radius
      logic [D_W-1:0]         lim_y;
   } geom_type;

endpackage

### hdl/cpct_front.sv
// ---------------------------------------------------------------------------
// cpct_front
// Scales sizes, classifies the pair and forms the doubled deltas and
// limits, registering the scaled sizes and then the geometry.
// ---------------------------------------------------------------------------
module cpct_front #(
   parameter int ID_BITS = cpct_pkg::ID_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [2*ID_BITS-1:0]          in_idx,
   input  logic                          a_kind,
   input  logic signed [cpct_pkg::POS_W-1:0]  ax,
   input  logic signed [cpct_pkg::POS_W-1:0]  ay,
   input  logic [cpct_pkg::SIZE_W-1:0]   aw,
   input  logic [cpct_pkg::SIZE_W-1:0]   ah,
   input  logic                          b_kind,
   input  logic signed [cpct_pkg::POS_W-1:0]  bx,
   input  logic signed [cpct_pkg::POS_W-1:0]  by,
   input  logic [cpct_pkg::SIZE_W-1:0]   bw,
   input  logic [cpct_pkg::SIZE_W-1:0]   bh,
   input  logic [cpct_pkg::SCALE_W-1:0]  scale,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [2*ID_BITS-1:0]          out_idx,
   output cpct_pkg::geom_type            out_geom
);
   import cpct_pkg::*;

   // stage 1: inputs held with scaled sizes
   logic                   s1_valid_ff, s1_valid_in;
   logic [2*ID_BITS-1:0]   s1_idx_ff;
   logic                   s1_ak_ff, s1_bk_ff;
   logic signed [POS_W-1:0] s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff;
   logic [SS_W-1:0]        s1_aw_ff, s1_ah_ff, s1_bw_ff, s1_bh_ff;
   logic                   s2_valid_ff, s2_valid_in;
   logic [2*ID_BITS-1:0]   s2_idx_ff;
   geom_type               s2_geom_ff, geom_in;
   logic                   s1_adv, s2_adv;

   assign s2_adv   = !s2_valid_ff || out_ready;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign in_ready = s1_adv;

   assign s1_valid_in = s1_adv ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;

   // advance control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // scale sizes into stage 1
   always_ff @(posedge clock) begin
      if (s1_adv && in_valid) begin
         s1_idx_ff <= in_idx;
         s1_ak_ff  <= a_kind;
         s1_bk_ff  <= b_kind;
         s1_ax_ff  <= ax;
         s1_ay_ff  <= ay;
         s1_bx_ff  <= bx;
         s1_by_ff  <= by;
         s1_aw_ff  <= SS_W'(aw) * SS_W'(scale);
         s1_ah_ff  <= SS_W'(ah) * SS_W'(scale);
         s1_bw_ff  <= SS_W'(bw) * SS_W'(scale);
         s1_bh_ff  <= SS_W'(bh) * SS_W'(scale);
      end
   end

   // classify and form deltas
   logic signed [D_W-1:0] ax2, ay2, bx2, by2, aw2, ah2, bw2, bh2;
   logic signed [D_W-1:0] acx, acy, bcx, bcy;
   logic signed [D_W-1:0] cx, cy, rx0, ry0, rx1, ry1, nx, ny;
   logic [D_W-1:0]        rad;

   always_comb begin
      ax2 = D_W'(s1_ax_ff) <<< 1;
      ay2 = D_W'(s1_ay_ff) <<< 1;
      bx2 = D_W'(s1_bx_ff) <<< 1;
      by2 = D_W'(s1_by_ff) <<< 1;
      aw2 = D_W'(s1_aw_ff);
      ah2 = D_W'(s1_ah_ff);
      bw2 = D_W'(s1_bw_ff);
      bh2 = D_W'(s1_bh_ff);
      acx = ax2 + aw2;
      acy = ay2 + ah2;
      bcx = bx2 + bw2;
      bcy = by2 + bh2;
      // circle centre and rectangle span, by which side is the circle
      if (s1_ak_ff == KIND_CIRCLE) begin
         cx  = acx;
         cy  = acy;
         rad = D_W'(s1_aw_ff);
         rx0 = bx2;
         ry0 = by2;
         rx1 = bx2 + (bw2 <<< 1);
         ry1 = by2 + (bh2 <<< 1);
      end else begin
         cx  = bcx;
         cy  = bcy;
         rad = D_W'(s1_bw_ff);
         rx0 = ax2;
         ry0 = ay2;
         rx1 = ax2 + (aw2 <<< 1);
         ry1 = ay2 + (ah2 <<< 1);
      end
      nx = (cx > rx1) ? rx1 : ((cx < rx0) ? rx0 : cx);
      ny = (cy > ry1) ? ry1 : ((cy < ry0) ? ry0 : cy);

      geom_in.mode = {s1_ak_ff, s1_bk_ff};
      case ({s1_ak_ff, s1_bk_ff})
         {KIND_RECT, KIND_RECT}: begin
            geom_in.dx    = ax2 - bx2;
            geom_in.dy    = ay2 - by2;
            geom_in.lim_x = D_W'(s1_aw_ff) + D_W'(s1_bw_ff);
            geom_in.lim_y = D_W'(s1_ah_ff) + D_W'(s1_bh_ff);
         end
         {KIND_CIRCLE, KIND_CIRCLE}: begin
            geom_in.dx    = acx - bcx;
            geom_in.dy    = acy - bcy;
            geom_in.lim_x = D_W'(s1_aw_ff) + D_W'(s1_bw_ff);
            geom_in.lim_y = '0;
         end
         default: begin
            geom_in.dx    = cx - nx;
            geom_in.dy    = cy - ny;
            geom_in.lim_x = rad;
            geom_in.lim_y = '0;
         end
      endcase
   end

   // hold stage 2 while the queue is full
   always_ff @(posedge clock) begin
      if (s2_adv && s1_valid_ff) begin
         s2_idx_ff  <= s1_idx_ff;
         s2_geom_ff <= geom_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_idx   = s2_idx_ff;
   assign out_geom  = s2_geom_ff;

endmodule

### hdl/cpct_queue.sv
// ---------------------------------------------------------------------------
// cpct_queue
// Two-entry word queue between the front and back parts.
// ---------------------------------------------------------------------------
module cpct_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             wr, rd;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;
   assign wp_in  = wr ? ~wp_ff : wp_ff;
   assign rp_in  = rd ? ~rp_ff : rp_ff;
   assign cnt_in = cnt_ff + {1'b0, wr} - {1'b0, rd};

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // store word
   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wp_ff] <= in_data;
      end
   end

endmodule

### hdl/cpct_back.sv
// ---------------------------------------------------------------------------
// cpct_back
// Clears the contact table after reset, then per word captures the
// magnitudes, squares them, decides the hit, updates the contact table
// and hands out the event word.
// ---------------------------------------------------------------------------
module cpct_back #(
   parameter int ID_BITS = cpct_pkg::ID_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [2*ID_BITS-1:0]     in_idx,
   input  cpct_pkg::geom_type       in_geom,
   output logic                     out_empty,
   input  logic                     out_pop,
   output logic [1:0]               out_event,
   output logic                     out_touch
);
   import cpct_pkg::*;
   localparam int DEPTH = 1 << (2 * ID_BITS);

   // sequencer: clear table, wait for a word, square, compare, hold result
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SQ    = 3'd2;
   localparam logic [2:0] ST_CMP   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]           st_ff, st_in;
   logic [2*ID_BITS-1:0] clr_ff, clr_in;
   logic [2*ID_BITS-1:0] idx_ff;
   logic [1:0]           mode_ff;
   logic [MAG_W-1:0]     mx_ff, my_ff, lx_ff, ly_ff;
   logic [2*MAG_W-1:0]   sqx_ff, sqy_ff, sqr_ff;
   logic [SQ_W-1:0]      sqd;
   logic [D_W-1:0]       mx, my;
   logic                 tab_mem [DEPTH];
   logic                 tab_we, tab_wd;
   logic [2*ID_BITS-1:0] tab_wa;
   logic                 was_ff;
   logic [1:0]           ev_ff;
   logic                 touch_ff, hit;

   assign mx = in_geom.dx[D_W-1] ? D_W'(-in_geom.dx) : D_W'(in_geom.dx);
   assign my = in_geom.dy[D_W-1] ? D_W'(-in_geom.dy) : D_W'(in_geom.dy);
   assign in_ready = (st_ff == ST_IDLE);
   assign clr_in = (st_ff == ST_CLEAR) ? clr_ff + (2*ID_BITS)'(1) : clr_ff;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_CLEAR: if (clr_ff == '1) st_in = ST_IDLE;
         ST_IDLE:  if (in_valid) st_in = ST_SQ;
         ST_SQ:    st_in = ST_CMP;
         ST_CMP:   st_in = ST_OUT;
         ST_OUT:   if (out_pop) st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   // sequence control and clear counter
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_CLEAR;
         clr_ff <= '0;
      end else begin
         st_ff  <= st_in;
         clr_ff <= clr_in;
      end
   end

   // contact table: one write port, registered read
   assign tab_we = (st_ff == ST_CLEAR) || (st_ff == ST_CMP);
   assign tab_wa = (st_ff == ST_CLEAR) ? clr_ff : idx_ff;
   assign tab_wd = (st_ff == ST_CLEAR) ? 1'b0 : hit;
   always_ff @(posedge clock) begin
      if (tab_we) tab_mem[tab_wa] <= tab_wd;
      if (st_ff == ST_IDLE && in_valid) was_ff <= tab_mem[in_idx];
   end

   // capture magnitudes
   always_ff @(posedge clock) begin
      if (st_ff == ST_IDLE && in_valid) begin
         idx_ff  <= in_idx;
         mode_ff <= in_geom.mode;
         mx_ff   <= mx[MAG_W-1:0];
         my_ff   <= my[MAG_W-1:0];
         lx_ff   <= in_geom.lim_x[MAG_W-1:0];
         ly_ff   <= in_geom.lim_y[MAG_W-1:0];
      end
   end

   // square the deltas and the radius
   always_ff @(posedge clock) begin
      if (st_ff == ST_SQ) begin
         sqx_ff <= mx_ff * mx_ff;
         sqy_ff <= my_ff * my_ff;
         sqr_ff <= lx_ff * lx_ff;
      end
   end

   assign sqd = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_comb begin
      if (mode_ff == {KIND_RECT, KIND_RECT})
         hit = (mx_ff < lx_ff) && (my_ff < ly_ff);
      else
         hit = sqd <= {1'b0, sqr_ff};
   end

   // latch event word
   always_ff @(posedge clock) begin
      if (st_ff == ST_CMP) begin
         touch_ff <= hit;
         ev_ff    <= hit ? (was_ff ? EV_STAY : EV_ENTER) : (was_ff ? EV_EXIT : EV_NONE);
      end
   end

   assign out_empty = (st_ff != ST_OUT);
   assign out_event = ev_ff;
   assign out_touch = touch_ff;

endmodule

### hdl/collider_pair_contact_tracker.sv
// ---------------------------------------------------------------------------
// collider_pair_contact_tracker
// Pair intersection test with per-pair enter/stay/exit tracking.
// ---------------------------------------------------------------------------
// Each pair takes two front stages (scale, then classify), passes a
// two-entry queue and then the back sequencer steps (capture, square,
// compare, result); the back takes no new item until its result is
// popped. A result that is not popped holds the back; the front and
// queue still take up to four more items before full rises. After
// reset the back clears all 1 << (2*ID_BITS) table entries (256 by
// default), one entry per cycle, before it takes its first item.
module collider_pair_contact_tracker #(
   parameter int ID_BITS = cpct_pkg::ID_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [3:0]                      req_first_id,
   input  logic [3:0]                      req_second_id,
   input  logic                            req_first_kind,
   input  logic signed [23:0]              req_first_x,
   input  logic signed [23:0]              req_first_y,
   input  logic [15:0]                     req_first_w,
   input  logic [15:0]                     req_first_h,
   input  logic                            req_second_kind,
   input  logic signed [23:0]              req_second_x,
   input  logic signed [23:0]              req_second_y,
   input  logic [15:0]                     req_second_w,
   input  logic [15:0]                     req_second_h,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [1:0]                      rsp_contact_event,
   output logic                            rsp_touching,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [0:0]                      paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import cpct_pkg::*;
   localparam int QW = 2 * ID_BITS + $bits(geom_type);

   logic [SCALE_W-1:0]   scale_ff;
   logic                 fr_ready, fr_valid, q_valid, q_ready;
   logic                 q_ready_f, qb_ready;
   logic [2*ID_BITS-1:0] fr_idx, q_idx, in_idx;
   geom_type             fr_geom, q_geom;
   logic [QW-1:0]        q_data;

   // configuration register
   assign pready = 1'b1;
   assign prdata = {24'd0, scale_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (psel && penable && pwrite && paddr == 1'b0) begin
         scale_ff <= pwdata[SCALE_W-1:0];
      end
   end

   assign in_idx   = {ID_BITS'(req_first_id), ID_BITS'(req_second_id)};
   assign req_full = !fr_ready;

   cpct_front #(.ID_BITS(ID_BITS)) u_front (
      .clock, .reset, .in_valid(req_push), .in_ready(fr_ready), .in_idx,
      .a_kind(req_first_kind), .ax(req_first_x), .ay(req_first_y),
      .aw(req_first_w), .ah(req_first_h),
      .b_kind(req_second_kind), .bx(req_second_x), .by(req_second_y),
      .bw(req_second_w), .bh(req_second_h), .scale(scale_ff),
      .out_valid(fr_valid), .out_ready(q_ready_f), .out_idx(fr_idx),
      .out_geom(fr_geom)
   );

   cpct_queue #(.WIDTH(QW)) u_queue (
      .clock, .reset, .in_valid(fr_valid), .in_ready(q_ready_f),
      .in_data({fr_idx, fr_geom}), .out_valid(q_valid), .out_ready(qb_ready),
      .out_data(q_data)
   );
   assign {q_idx, q_geom} = q_data;
   assign q_ready = qb_ready;

   cpct_back #(.ID_BITS(ID_BITS)) u_back (
      .clock, .reset, .in_valid(q_valid), .in_ready(qb_ready), .in_idx(q_idx),
      .in_geom(q_geom), .out_empty(rsp_empty), .out_pop(rsp_pop),
      .out_event(rsp_contact_event), .out_touch(rsp_touching)
   );

   // touching and the event agree
   a_ev_touch: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_touching == (rsp_contact_event == EV_ENTER ||
                                       rsp_contact_event == EV_STAY)))
      else $error("event and touching disagree");
   // a waiting result holds until popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_contact_event)))
      else $error("result dropped");
   // a queue word that the back side does not take stays valid
   a_q: assert property (@(posedge clock) disable iff (reset)
      (q_valid && !q_ready) |=> q_valid)
      else $error("queue lost a word");

endmodule

### dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the collider pair contact tracker. A directed table covers
// the extreme fields, every pair of shape kinds, zero scale, equal ids and
// the circle-height case, then random pair words stream through under
// several idle and stall patterns. A scoreboard predicts each contact event
// and touch flag and compares them in order against the popped words.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cpct_pkg::*;

   typedef struct packed {
      logic [3:0]         a_id;
      logic [3:0]         b_id;
      logic               a_kind;
      logic signed [23:0] ax;
      logic signed [23:0] ay;
      logic [15:0]        aw;
      logic [15:0]        ah;
      logic               b_kind;
      logic signed [23:0] bx;
      logic signed [23:0] by;
      logic [15:0]        bw;
      logic [15:0]        bh;
   } pair_type;

   localparam int PAIR_W = $bits(pair_type);

   typedef struct packed {
      logic [1:0] ev;
      logic       touch;
   } contact_type;

   // Directed row: pair, scale to apply first, and an optional typed answer.
   typedef struct {
      pair_type      pair;
      int            scale;   // -1 keeps the current scale
      bit            known;
      contact_type   answer;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   pair_type drv = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [1:0] rsp_contact_event;
   logic rsp_touching;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [0:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   always #10 clock = ~clock;

   collider_pair_contact_tracker dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_first_id(drv.a_id), .req_second_id(drv.b_id),
      .req_first_kind(drv.a_kind), .req_first_x(drv.ax), .req_first_y(drv.ay),
      .req_first_w(drv.aw), .req_first_h(drv.ah),
      .req_second_kind(drv.b_kind), .req_second_x(drv.bx), .req_second_y(drv.by),
      .req_second_w(drv.bw), .req_second_h(drv.bh),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_contact_event(rsp_contact_event), .rsp_touching(rsp_touching),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor state
   bit           contact_flags [256];
   logic [7:0]   scale_now = SCALE_RESET;
   contact_type  pending_contacts [$];
   contact_type  typed_answers [$];
   bit           typed_valid [$];
   int           errors = 0;
   int           send_idle = 0;   // percent
   int           recv_stall = 0;  // percent
   bit           hold_off = 1'b0;
   int           idle_cycles = 0;
   row_type      rows [$];

   function automatic logic [63:0] absd(input logic signed [63:0] v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic bit circle_hits_rect(input logic signed [63:0] cx2, cy2, cr2,
         input logic signed [63:0] px, py, sw, sh);
      logic signed [63:0] nx, ny;
      logic [63:0] dx, dy;
      nx = cx2;
      if (nx > 2*px + 2*sw) nx = 2*px + 2*sw;
      if (nx < 2*px) nx = 2*px;
      ny = cy2;
      if (ny > 2*py + 2*sh) ny = 2*py + 2*sh;
      if (ny < 2*py) ny = 2*py;
      dx = absd(cx2 - nx);
      dy = absd(cy2 - ny);
      return dx*dx + dy*dy <= cr2*cr2;
   endfunction

   // Work out the contact word for one pair and update the flag table.
   function automatic contact_type track_contact(input pair_type p);
      logic signed [63:0] ax, ay, bx, by, aw, ah, bw, bh;
      logic [63:0] dx, dy, r;
      logic [7:0] idx;
      bit hit, was;
      contact_type c;
      ax = 64'(p.ax); ay = 64'(p.ay); bx = 64'(p.bx); by = 64'(p.by);
      aw = 64'(p.aw) * 64'(scale_now); ah = 64'(p.ah) * 64'(scale_now);
      bw = 64'(p.bw) * 64'(scale_now); bh = 64'(p.bh) * 64'(scale_now);
      idx = {p.a_id, p.b_id};
      was = contact_flags[idx];
      if (p.a_kind == KIND_RECT && p.b_kind == KIND_RECT) begin
         hit = (2*absd(ax - bx) < aw + bw) && (2*absd(ay - by) < ah + bh);
      end else if (p.a_kind == KIND_CIRCLE && p.b_kind == KIND_CIRCLE) begin
         dx = absd((2*ax + aw) - (2*bx + bw));
         dy = absd((2*ay + ah) - (2*by + bh));
         r = aw + bw;
         hit = dx*dx + dy*dy <= r*r;
      end else if (p.a_kind == KIND_CIRCLE) begin
         hit = circle_hits_rect(2*ax + aw, 2*ay + ah, aw, bx, by, bw, bh);
      end else begin
         hit = circle_hits_rect(2*bx + bw, 2*by + bh, bw, ax, ay, aw, ah);
      end
      c.touch = hit;
      if (hit) begin
         c.ev = was ? EV_STAY : EV_ENTER;
         contact_flags[idx] = 1'b1;
      end else if (was) begin
         c.ev = EV_EXIT;
         contact_flags[idx] = 1'b0;
      end else begin
         c.ev = EV_NONE;
      end
      return c;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR %0t %s: got %0d expected %0d", $time, what, got, want);
      errors++;
   endtask

   task automatic write_scale(input logic [7:0] v);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {24'd0, v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      scale_now = v;
   endtask

   // Drain: drop push, then wait until every expected word has come back.
   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_contacts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Offer one word; the predictor runs when it is accepted. Push stays
   // high afterwards; the next call or a drain drives it again.
   task automatic send_pair(input pair_type p, input bit known, input contact_type ans);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      drv <= p;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      pending_contacts.push_back(track_contact(p));
      typed_valid.push_back(known);
      typed_answers.push_back(ans);
   endtask

   function automatic pair_type random_pair(input bit near);
      pair_type p;
      p = PAIR_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom});
      if ($urandom_range(3) != 0) p.a_id = 4'($urandom_range(3));
      if ($urandom_range(3) != 0) p.b_id = 4'($urandom_range(3));
      if (near) begin
         // keep positions close and sizes modest so contacts come and go
         p.ax = 24'($signed($urandom_range(4000)) - 2000);
         p.ay = 24'($signed($urandom_range(4000)) - 2000);
         p.bx = p.ax + 24'($signed($urandom_range(3000)) - 1500);
         p.by = p.ay + 24'($signed($urandom_range(3000)) - 1500);
         p.aw = 16'($urandom_range(20)); p.ah = 16'($urandom_range(20));
         p.bw = 16'($urandom_range(20)); p.bh = 16'($urandom_range(20));
      end
      return p;
   endfunction

   // Pop side: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset || hold_off) rsp_pop <= 1'b0;
      else rsp_pop <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
   end

   // Check each popped word against the oldest prediction.
   always @(posedge clock) begin
      contact_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_contacts.size() == 0) begin
            report_mismatch("unexpected word", rsp_contact_event, -1);
         end else begin
            want = pending_contacts.pop_front();
            if (typed_valid.pop_front() && typed_answers[0] != want)
               report_mismatch("predictor vs table", typed_answers[0], want);
            void'(typed_answers.pop_front());
            if (rsp_contact_event !== want.ev)
               report_mismatch("contact_event", rsp_contact_event, want.ev);
            if (rsp_touching !== want.touch)
               report_mismatch("touching", rsp_touching, want.touch);
         end
      end
   end

   // Watchdog on cycles without any accepted or popped word or bus access.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || psel || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("FAIL collider_pair_contact_tracker");
         $finish;
      end
   end

   function automatic pair_type mk(input int ia, ib, input bit ka, kb,
         input int ax, ay, aw, ah, bx, by, bw, bh);
      pair_type p;
      p.a_id = 4'(ia); p.b_id = 4'(ib); p.a_kind = ka; p.b_kind = kb;
      p.ax = 24'(ax); p.ay = 24'(ay); p.aw = 16'(aw); p.ah = 16'(ah);
      p.bx = 24'(bx); p.by = 24'(by); p.bw = 16'(bw); p.bh = 16'(bh);
      return p;
   endfunction

   task automatic add_row(input pair_type p, input int sc, input bit kn,
         input contact_type an);
      row_type rw;
      rw.pair = p;
      rw.scale = sc;
      rw.known = kn;
      rw.answer = an;
      rows.push_back(rw);
   endtask

   initial begin
      contact_type none_c, enter_c, stay_c, exit_c;
      pair_type pr;
      int phase;
      none_c = {EV_NONE, 1'b0}; enter_c = {EV_ENTER, 1'b1};
      stay_c = {EV_STAY, 1'b1}; exit_c = {EV_EXIT, 1'b0};
      // rect-rect: enter, stay, exit, none on one pair
      pr = mk(1, 2, KIND_RECT, KIND_RECT, 0, 0, 2, 2, 100, 100, 2, 2);
      add_row(pr, -1, 1, enter_c);
      add_row(pr, -1, 1, stay_c);
      pr = mk(1, 2, KIND_RECT, KIND_RECT, 0, 0, 2, 2, 8388607, 0, 2, 2);
      add_row(pr, -1, 1, exit_c);
      add_row(pr, -1, 1, none_c);
      // strict edge: distance equals half-sum scaled (100*2*... = 200 each side)
      add_row(mk(3, 3, KIND_RECT, KIND_RECT, 0, 0, 2, 2, 200, 0, 2, 2), -1, 0, none_c);
      // extremes of position and size
      add_row(mk(15, 15, KIND_RECT, KIND_RECT, -8388608, -8388608, 65535, 65535,
                 8388607, 8388607, 65535, 65535), -1, 0, none_c);
      add_row(mk(15, 0, KIND_CIRCLE, KIND_CIRCLE, -8388608, 8388607, 65535, 0,
                 8388607, -8388608, 65535, 65535), -1, 0, none_c);
      add_row(mk(0, 15, KIND_CIRCLE, KIND_RECT, 8388607, 8388607, 65535, 65535,
                 -8388608, -8388608, 65535, 65535), -1, 0, none_c);
      add_row(mk(0, 15, KIND_RECT, KIND_CIRCLE, 0, 0, 10, 10, 5, 5, 3, 3), -1, 0, none_c);
      add_row(mk(4, 5, KIND_CIRCLE, KIND_RECT, 0, 0, 1, 1, 5000, 5000, 1, 1), -1, 0, none_c);
      // circle height moves the centre only
      add_row(mk(6, 7, KIND_CIRCLE, KIND_CIRCLE, 0, 0, 1, 200, 0, 0, 1, 0), -1, 0, none_c);
      // same id twice
      add_row(mk(9, 9, KIND_CIRCLE, KIND_CIRCLE, 0, 0, 4, 4, 0, 0, 4, 4), -1, 0, none_c);
      // zero scale: rects never touch, circles only on equal centres
      add_row(mk(10, 11, KIND_RECT, KIND_RECT, 0, 0, 9, 9, 0, 0, 9, 9), 0, 1, none_c);
      add_row(mk(10, 12, KIND_CIRCLE, KIND_CIRCLE, 5, 5, 9, 9, 5, 5, 1, 1), -1, 1, enter_c);
      add_row(mk(10, 12, KIND_CIRCLE, KIND_CIRCLE, 5, 5, 9, 9, 6, 5, 1, 1), -1, 1, exit_c);
      add_row(mk(10, 13, KIND_RECT, KIND_CIRCLE, 5, 5, 9, 9, 5, 5, 1, 1), -1, 0, none_c);
      // full scale
      add_row(mk(13, 14, KIND_CIRCLE, KIND_RECT, 0, 0, 65535, 65535,
                 100, 100, 65535, 65535), 255, 0, none_c);
      add_row(mk(14, 13, KIND_RECT, KIND_RECT, 0, 0, 65535, 65535,
                 -8388608, 8388607, 65535, 65535), -1, 0, none_c);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (rows[i]) begin
         if (rows[i].scale >= 0) begin
            wait_drained();
            write_scale(8'(rows[i].scale));
         end
         send_pair(rows[i].pair, rows[i].known, rows[i].answer);
      end
      wait_drained();
      write_scale(SCALE_RESET);

      // random phases: idle/stall patterns and scale settings
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 84; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 84; end
            3: begin send_idle = 21; recv_stall = 21; end
            4: begin send_idle = 0;  recv_stall = 0;  end
            default: begin send_idle = 21; recv_stall = 21; end
         endcase
         wait_drained();
         write_scale(phase == 4 ? 8'd0 :
                     (phase == 5 ? 8'd255 : 8'($urandom_range(255))));
         if (phase == 0) begin
            // long hold-off on the pop side so the input backs up
            fork
               begin
                  hold_off = 1'b1;
                  repeat (300) @(posedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
         repeat (255) send_pair(random_pair($urandom_range(4) != 0), 1'b0, '0);
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("PASS collider_pair_contact_tracker");
      else
         $display("FAIL collider_pair_contact_tracker");
      $finish;
   end

endmodule
